// ===== hdl/mepc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mepc_pkg;
	localparam int TableSizeDefault = 4096;
	localparam int MaterialBins = 8;
	localparam logic [31:0] FnvBasis = 32'd2166136261;
	localparam logic [31:0] FnvPrime = 32'd16777619;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;

	localparam logic [2:0] ST_NEW    = 3'd0;
	localparam logic [2:0] ST_REPEAT = 3'd1;
	localparam logic [2:0] ST_ROAD   = 3'd2;
	localparam logic [2:0] ST_POINT  = 3'd3;
	localparam logic [2:0] ST_VERT   = 3'd4;
	localparam logic [2:0] ST_FULL   = 3'd5;
	localparam logic [2:0] ST_SCAN   = 3'd6;
	localparam logic [2:0] ST_QUERY  = 3'd7;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture item, order ends
		logic hash_init; // seed hash
		logic hash_step; // fold one word
		logic probe_rd;  // issue table read at probe slot
		logic probe_adv; // advance probe slot
		logic ins_new;   // write new entry
		logic ins_rep;   // bump count
		logic scan_init; // zero tallies and scan address
		logic scan_rd;   // read at scan address
		logic scan_eval; // tally and clear slot, advance
		logic done;      // present result
		logic [2:0] rstat;
	} mepc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip_road;
		logic skip_point;
		logic skip_vert;
		logic hash_last;
		logic slot_empty;
		logic slot_match;
		logic probe_last;
		logic scan_last;
	} mepc_sts_t;
endpackage
`default_nettype wire

// ===== hdl/mesh_edge_pair_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An insert hashes the item, then probes with a read and an evaluate state per slot.
// Finish walks the whole single-port table, reading and then evaluating each slot.
// One item at a time; busy drops in the cycle that carries the result strobe.
// Reset: async arst_n clears control and tallies, then a clearing pass zeroes
// the count memory; start is not taken meanwhile.
// The receiver cannot stall: done marks a result for one cycle.
module mesh_edge_pair_counter import mepc_pkg::*; #(
	parameter int TABLE_SIZE = TableSizeDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic signed [12:0] first_x,
	input  wire logic signed [12:0] first_y,
	input  wire logic signed [15:0] first_z,
	input  wire logic signed [12:0] second_x,
	input  wire logic signed [12:0] second_y,
	input  wire logic signed [15:0] second_z,
	input  wire logic [3:0]  material,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data,
	output logic             done,
	output logic [2:0]       status,
	output logic [7:0]       edge_count,
	output logic [15:0]      free_total,
	output logic [15:0]      material_free
);
	mepc_cmd_t cmd;
	mepc_sts_t sts;
	logic      ctrl_busy;
	logic      clearing_q;
	logic [$clog2(TABLE_SIZE):0] clr_cnt_q;
	logic [4:0] road_min_q;

	// Take a config beat whenever offered.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) road_min_q <= 5'd7;
		else if (cfg_valid) road_min_q <= cfg_data;
	end

	// Mirror the datapath clearing pass so start is held off during it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ($clog2(TABLE_SIZE)+1)'(TABLE_SIZE - 1)) clearing_q <= 1'b0;
		end
	end

	assign busy = ctrl_busy || clearing_q;

	mepc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start && !clearing_q), .mode(mode),
		.sts(sts), .busy(ctrl_busy), .cmd(cmd)
	);

	mepc_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .road_min(road_min_q),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.material(material), .sts(sts), .done(done), .status(status),
		.edge_count(edge_count), .free_total(free_total),
		.material_free(material_free)
	);
endmodule
`default_nettype wire

// ===== hdl/mepc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mepc_ctrl import mepc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic [1:0] mode,
	input  wire mepc_sts_t sts,
	output logic           busy,
	output mepc_cmd_t      cmd
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_HASH  = 9'b000000100,
		S_PRD   = 9'b000001000,
		S_PEVAL = 9'b000010000,
		S_SRD   = 9'b000100000,
		S_SEVAL = 9'b001000000,
		S_DONE  = 9'b010000000,
		S_SWAIT = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] rstat_q, rstat_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rstat_q <= ST_NEW;
		end else begin
			state_q <= state_d;
			rstat_q <= rstat_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rstat_d = rstat_q;
		cmd = '0;
		cmd.rstat = rstat_q;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					priority if (mode == MODE_INSERT) begin
						state_d = S_CHECK;
					end else if (mode == MODE_FINISH) begin
						cmd.scan_init = 1'b1;
						state_d = S_SRD;
					end else begin
						rstat_d = ST_QUERY;
						state_d = S_DONE;
					end
				end
			end
			S_CHECK: begin
				cmd.hash_init = 1'b1;
				priority if (sts.skip_road) begin
					rstat_d = ST_ROAD;
					state_d = S_DONE;
				end else if (sts.skip_point) begin
					rstat_d = ST_POINT;
					state_d = S_DONE;
				end else if (sts.skip_vert) begin
					rstat_d = ST_VERT;
					state_d = S_DONE;
				end else begin
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) state_d = S_PRD;
			end
			S_PRD: begin
				cmd.probe_rd = 1'b1;
				state_d = S_PEVAL;
			end
			S_PEVAL: begin
				priority if (sts.slot_empty) begin
					cmd.ins_new = 1'b1;
					rstat_d = ST_NEW;
					state_d = S_DONE;
				end else if (sts.slot_match) begin
					cmd.ins_rep = 1'b1;
					rstat_d = ST_REPEAT;
					state_d = S_DONE;
				end else if (sts.probe_last) begin
					rstat_d = ST_FULL;
					state_d = S_DONE;
				end else begin
					cmd.probe_adv = 1'b1;
					state_d = S_PRD;
				end
			end
			S_SRD: begin
				cmd.scan_rd = 1'b1;
				state_d = S_SEVAL;
			end
			S_SEVAL: begin
				cmd.scan_eval = 1'b1;
				if (sts.scan_last) begin
					rstat_d = ST_SCAN;
					state_d = S_SWAIT;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SWAIT: state_d = S_DONE;
			S_DONE: begin
				cmd.done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> !cmd.done) else $error("double result");
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins_new && cmd.ins_rep)) else $error("two writes");
endmodule
`default_nettype wire

// ===== hdl/mepc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mepc_dp import mepc_pkg::*; #(
	parameter int TABLE_SIZE = TableSizeDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mepc_cmd_t   cmd,
	input  wire logic [4:0]  road_min,
	input  wire logic signed [12:0] first_x,
	input  wire logic signed [12:0] first_y,
	input  wire logic signed [15:0] first_z,
	input  wire logic signed [12:0] second_x,
	input  wire logic signed [12:0] second_y,
	input  wire logic signed [15:0] second_z,
	input  wire logic [3:0]  material,
	output mepc_sts_t        sts,
	output logic             done,
	output logic [2:0]       status,
	output logic [7:0]       edge_count,
	output logic [15:0]      free_total,
	output logic [15:0]      material_free
);
	localparam int AW = $clog2(TABLE_SIZE);

	logic [41:0] lo_q, hi_q;
	logic [3:0]  mat_q;
	logic [31:0] hash_q;
	logic [2:0]  hstep_q;
	logic [AW-1:0] addr_q;
	logic [AW:0]   probes_q;

	logic [41:0] mem_lo [TABLE_SIZE];
	logic [41:0] mem_hi [TABLE_SIZE];
	logic [2:0]  mem_mat [TABLE_SIZE];
	logic [7:0]  mem_cnt [TABLE_SIZE];
	logic [41:0] rd_lo_q, rd_hi_q;
	logic [2:0]  rd_mat_q;
	logic [7:0]  rd_cnt_q;

	logic [15:0] free_q;
	logic [15:0] tally_q [MaterialBins];
	logic [7:0]  cnt_res_q;
	logic        done_q;
	logic [2:0]  stat_q;

	// order endpoints lexicographically, signed
	logic b_less;
	always_comb begin
		priority if (first_x != second_x) b_less = second_x < first_x;
		else if (first_y != second_y) b_less = second_y < first_y;
		else b_less = second_z < first_z;
	end

	logic [41:0] pa, pb;
	assign pa = {first_z, first_y, first_x};
	assign pb = {second_z, second_y, second_x};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= b_less ? pb : pa;
			hi_q <= b_less ? pa : pb;
			mat_q <= material;
		end
	end

	// skip checks use the captured ends (order does not matter)
	assign sts.skip_road  = {1'b0, mat_q} >= road_min;
	assign sts.skip_point = (lo_q == hi_q);
	assign sts.skip_vert  = (lo_q[25:0] == hi_q[25:0]);

	// word sequence: lo x, hi x, lo y, hi y, lo z, hi z
	logic [31:0] word;
	always_comb begin
		unique case (hstep_q)
			3'd0: word = {{19{lo_q[12]}}, lo_q[12:0]};
			3'd1: word = {{19{hi_q[12]}}, hi_q[12:0]};
			3'd2: word = {{19{lo_q[25]}}, lo_q[25:13]};
			3'd3: word = {{19{hi_q[25]}}, hi_q[25:13]};
			3'd4: word = {{16{lo_q[41]}}, lo_q[41:26]};
			default: word = {{16{hi_q[41]}}, hi_q[41:26]};
		endcase
	end
	logic [31:0] hash_next;
	assign hash_next = (hash_q ^ word) * FnvPrime;
	assign sts.hash_last = (hstep_q == 3'd5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstep_q  <= '0;
			addr_q   <= '0;
			probes_q <= '0;
		end else begin
			if (cmd.hash_init) begin
				hstep_q <= '0;
			end else if (cmd.hash_step) begin
				hstep_q <= hstep_q + 3'd1;
			end
			if (cmd.hash_step && sts.hash_last) begin
				addr_q <= hash_next[AW-1:0];
				probes_q <= '0;
			end else if (cmd.probe_adv) begin
				addr_q <= addr_q + 1'b1;
				probes_q <= probes_q + 1'b1;
			end else if (cmd.scan_init) begin
				addr_q <= '0;
			end else if (cmd.scan_eval) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hash_init) hash_q <= FnvBasis;
		else if (cmd.hash_step) hash_q <= hash_next;
	end

	assign sts.slot_empty = (rd_cnt_q == 8'd0);
	assign sts.slot_match = (rd_lo_q == lo_q) && (rd_hi_q == hi_q);
	assign sts.probe_last = (probes_q == (AW+1)'(TABLE_SIZE - 1));
	assign sts.scan_last  = (addr_q == {AW{1'b1}});

	// key memories
	always_ff @(posedge clk) begin
		if (cmd.ins_new) begin
			mem_lo[addr_q] <= lo_q;
			mem_hi[addr_q] <= hi_q;
			mem_mat[addr_q] <= mat_q[2:0];
		end
		if (cmd.probe_rd || cmd.scan_rd) begin
			rd_lo_q <= mem_lo[addr_q];
			rd_hi_q <= mem_hi[addr_q];
			rd_mat_q <= mem_mat[addr_q];
		end
	end

	// count memory: cleared after reset by the sweep below, and slot by slot by the scan of a finish
	logic        clr_busy_q;
	logic [AW:0] clr_addr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == (AW+1)'(TABLE_SIZE - 1)) clr_busy_q <= 1'b0;
		end
	end

	logic [7:0] cnt_inc;
	assign cnt_inc = (rd_cnt_q == 8'hFF) ? 8'hFF : rd_cnt_q + 8'd1;

	always_ff @(posedge clk) begin
		if (clr_busy_q) mem_cnt[clr_addr_q[AW-1:0]] <= 8'd0;
		else if (cmd.ins_new) mem_cnt[addr_q] <= 8'd1;
		else if (cmd.ins_rep) mem_cnt[addr_q] <= cnt_inc;
		else if (cmd.scan_eval) mem_cnt[addr_q] <= 8'd0;
		if (cmd.probe_rd || cmd.scan_rd) rd_cnt_q <= mem_cnt[addr_q];
	end

	logic is_free;
	assign is_free = (rd_cnt_q == 8'd1) && !(rd_lo_q[41:26] == 16'd0 && rd_hi_q[41:26] == 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
			for (int i = 0; i < MaterialBins; i++) tally_q[i] <= '0;
			done_q <= 1'b0;
			stat_q <= ST_NEW;
			cnt_res_q <= '0;
		end else begin
			done_q <= cmd.done;
			if (cmd.done) stat_q <= cmd.rstat;
			if (cmd.load) cnt_res_q <= '0;
			else if (cmd.ins_new) cnt_res_q <= 8'd1;
			else if (cmd.ins_rep) cnt_res_q <= cnt_inc;
			if (cmd.scan_init) begin
				free_q <= '0;
				for (int i = 0; i < MaterialBins; i++) tally_q[i] <= '0;
			end else if (cmd.scan_eval && is_free) begin
				if (free_q != 16'hFFFF) free_q <= free_q + 16'd1;
				if (tally_q[rd_mat_q] != 16'hFFFF)
					tally_q[rd_mat_q] <= tally_q[rd_mat_q] + 16'd1;
			end
		end
	end

	assign done = done_q;
	assign status = stat_q;
	assign edge_count = cnt_res_q;
	assign free_total = free_q;
	assign material_free = tally_q[mat_q[2:0]];

	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_new |=> cnt_res_q == 8'd1) else $error("new count not one");
	a_no_ins_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !(cmd.ins_new || cmd.ins_rep || cmd.scan_eval))
		else $error("table write during clear");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_adv |-> probes_q != (AW+1)'(TABLE_SIZE - 1))
		else $error("probe overrun");
endmodule
`default_nettype wire
